// ----- hw/rtl/ate_pkg.sv -----
// ate_pkg: types, constants and codes for the ansi text console engine
// no dependencies
`default_nettype none

package ate_pkg;

   localparam int ROWS_DEF        = 25;
   localparam int COLUMNS_DEF     = 80;
   localparam int PARAM_SLOTS_DEF = 10;

   localparam logic [15:0] PARAM_MAX = 16'hFFFF;
   localparam logic [3:0]  FG_WHITE  = 4'd7;
   localparam logic [3:0]  BG_BLACK  = 4'd0;

   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SAVE  = 8'h37;
   localparam logic [7:0] CH_REST  = 8'h38;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_SGR   = 8'h6D;
   localparam logic [7:0] CH_LEFT  = 8'h44;
   localparam logic [7:0] CH_RIGHT = 8'h43;
   localparam logic [7:0] CH_POS_H = 8'h48;
   localparam logic [7:0] CH_POS_F = 8'h66;
   localparam logic [7:0] CH_ERASE = 8'h4A;

   localparam logic [15:0] SGR_FG_LO = 16'd30;
   localparam logic [15:0] SGR_FG_HI = 16'd37;
   localparam logic [15:0] SGR_BG_LO = 16'd40;
   localparam logic [15:0] SGR_BG_HI = 16'd47;
   localparam logic [15:0] SGR_FG_DF = 16'd39;
   localparam logic [15:0] SGR_BG_DF = 16'd49;
   localparam logic [15:0] ERASE_ALL = 16'd2;

   typedef enum logic [0:0] {
      FN_WRITE = 1'b0,
      FN_READ  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_ESC    = 2'd1,
      MODE_CSI    = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_RESP,
      ST_SGR,
      ST_SCROLL,
      ST_FILL
   } state_type;

   typedef struct packed {
      logic       func;
      logic [7:0] char_byte;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } req_type;

   typedef struct packed {
      logic [7:0] cell_char;
      logic [3:0] cell_fg;
      logic [3:0] cell_bg;
      logic [4:0] cursor_row_out;
      logic [6:0] cursor_col_out;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hw/rtl/ansi_text_console_engine.sv -----
// ansi_text_console_engine: byte-stream text terminal with screen memory
// depends on ate_pkg
`default_nettype none

// channel | direction | handshake          | payload
// req_    | in        | req_valid/req_stall | ate_pkg::req_type
// rsp_    | out       | rsp_valid/rsp_stall | ate_pkg::rsp_type
// a plain byte goes through ST_RESP and a cell read through ST_READ, which takes the registered memory read
// sgr runs through ST_SGR, one parameter per cycle
// scroll copies each row up a row (one read and one write per cycle), then blanks the last row
// erase all blanks the whole screen, one cell written per cycle
// after reset a clearing pass over every cell runs before req is taken
// one transaction in flight; req_stall stays high until the result has left

module ansi_text_console_engine #(
   parameter int ROWS        = ate_pkg::ROWS_DEF,
   parameter int COLUMNS     = ate_pkg::COLUMNS_DEF,
   parameter int PARAM_SLOTS = ate_pkg::PARAM_SLOTS_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  ate_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output ate_pkg::rsp_type  rsp_data
);
   import ate_pkg::*;

   localparam int TOTAL   = ROWS * COLUMNS;
   localparam int ADDR_W  = $clog2(TOTAL);
   localparam int ROW_W   = $clog2(ROWS);
   localparam int COL_W   = $clog2(COLUMNS);
   localparam int SLOT_W  = $clog2(PARAM_SLOTS);
   localparam int SCR_END = (ROWS - 1) * COLUMNS;

   localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(PARAM_SLOTS - 1);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(TOTAL - 1);
   localparam logic [ADDR_W-1:0] SCR_LAST  = ADDR_W'(SCR_END);

   logic [15:0] screen_mem [TOTAL];
   logic [15:0] mem_rd_ff;

   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic [ROW_W-1:0]  crow_ff, crow_in, srow_ff, srow_in;
   logic [COL_W-1:0]  ccol_ff, ccol_in, scol_ff, scol_in;
   logic [3:0]        fg_ff, fg_in, bg_ff, bg_in;
   logic [15:0]       par_ff [PARAM_SLOTS];
   logic [15:0]       par_in [PARAM_SLOTS];
   logic [SLOT_W-1:0] slot_ff, slot_in, sgr_ff, sgr_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic              rd_ok_ff, rd_ok_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic              accept;
   logic              go_scroll, go_fill, go_sgr;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa, mem_ra;
   logic [15:0]       mem_wd;
   logic [ROW_W-1:0]  wr_row;
   logic [COL_W-1:0]  wr_col;
   logic [7:0]        wr_char;
   logic              idle_we;
   logic [SLOT_W-1:0] par_idx;
   logic [15:0]       par_rd, p0, p1, move_n;
   logic [19:0]       digit_v;
   logic [16:0]       right_sum;
   logic              rd_in_range;
   logic [7:0]        b;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign b       = req_data.char_byte;
   assign par_idx = (state_ff == ST_SGR) ? sgr_ff : slot_ff;
   assign par_rd  = par_ff[par_idx];
   assign p0      = par_ff[0];
   assign p1      = par_ff[1];
   assign move_n  = (p0 == 16'd0) ? 16'd1 : p0;
   assign digit_v = 20'(par_rd) * 20'd10 + 20'(b - CH_ZERO);
   assign right_sum = 17'(ccol_ff) + 17'(move_n);
   assign rd_in_range = (32'(req_data.read_row) < ROWS) && (32'(req_data.read_col) < COLUMNS);

   // byte decode and cursor update
   always_comb begin
      mode_in   = mode_ff;
      crow_in   = crow_ff;
      ccol_in   = ccol_ff;
      srow_in   = srow_ff;
      scol_in   = scol_ff;
      fg_in     = fg_ff;
      bg_in     = bg_ff;
      par_in    = par_ff;
      slot_in   = slot_ff;
      sgr_in    = sgr_ff;
      rd_ok_in  = rd_ok_ff;
      go_scroll = 1'b0;
      go_fill   = 1'b0;
      go_sgr    = 1'b0;
      idle_we   = 1'b0;
      wr_row    = crow_ff;
      wr_col    = ccol_ff;
      wr_char   = b;
      if (accept && req_data.func == FN_READ) begin
         rd_ok_in = rd_in_range;
      end else if (accept) begin
         unique case (mode_ff)
            MODE_ESC: begin
               mode_in = MODE_NORMAL;
               if (b == CH_SAVE) begin
                  srow_in = crow_ff;
                  scol_in = ccol_ff;
               end else if (b == CH_REST) begin
                  crow_in = srow_ff;
                  ccol_in = scol_ff;
               end else if (b == CH_LBRK) begin
                  for (int i = 0; i < PARAM_SLOTS; i++) par_in[i] = 16'd0;
                  slot_in = '0;
                  mode_in = MODE_CSI;
               end
            end
            MODE_CSI: begin
               if (b >= CH_ZERO && b <= CH_NINE) begin
                  par_in[slot_ff] = (digit_v > 20'(PARAM_MAX)) ? PARAM_MAX : digit_v[15:0];
               end else if (b == CH_SEMI) begin
                  if (slot_ff < SLOT_LAST) slot_in = slot_ff + 1'b1;
               end else begin
                  mode_in = MODE_NORMAL;
                  if (b == CH_SGR) begin
                     go_sgr = 1'b1;
                     sgr_in = '0;
                  end else if (b == CH_LEFT) begin
                     ccol_in = (move_n >= 16'(ccol_ff)) ? '0 : ccol_ff - COL_W'(move_n);
                  end else if (b == CH_RIGHT) begin
                     ccol_in = (right_sum >= 17'(COLUMNS)) ? COL_LAST : right_sum[COL_W-1:0];
                  end else if (b == CH_POS_H || b == CH_POS_F) begin
                     crow_in = (p0 >= 16'(ROWS)) ? ROW_LAST : p0[ROW_W-1:0];
                     ccol_in = (p1 >= 16'(COLUMNS)) ? COL_LAST : p1[COL_W-1:0];
                  end else if (b == CH_ERASE && p0 == ERASE_ALL) begin
                     go_fill = 1'b1;
                     crow_in = '0;
                     ccol_in = '0;
                  end
               end
            end
            default: begin
               if (b == CH_ESC) begin
                  mode_in = MODE_ESC;
               end else if (b == CH_DEL || b == CH_BS) begin
                  if (ccol_ff != '0) begin
                     ccol_in = ccol_ff - 1'b1;
                     idle_we = (b == CH_DEL);
                  end else if (crow_ff != '0) begin
                     crow_in = crow_ff - 1'b1;
                     ccol_in = COL_LAST;
                     idle_we = (b == CH_DEL);
                  end
                  wr_row  = crow_in;
                  wr_col  = ccol_in;
                  wr_char = CH_SPACE;
               end else if (b == CH_CR) begin
                  ccol_in = '0;
               end else if (b == CH_LF) begin
                  if (crow_ff == ROW_LAST) go_scroll = 1'b1;
                  else crow_in = crow_ff + 1'b1;
               end else if (b >= CH_SPACE && b <= CH_TILDE) begin
                  idle_we = 1'b1;
                  if (ccol_ff == COL_LAST) begin
                     ccol_in = '0;
                     if (crow_ff == ROW_LAST) go_scroll = 1'b1;
                     else crow_in = crow_ff + 1'b1;
                  end else begin
                     ccol_in = ccol_ff + 1'b1;
                  end
               end
            end
         endcase
      end
      if (state_ff == ST_SGR) begin
         if (par_rd >= SGR_FG_LO && par_rd <= SGR_FG_HI) fg_in = 4'(par_rd - SGR_FG_LO);
         else if (par_rd >= SGR_BG_LO && par_rd <= SGR_BG_HI) bg_in = 4'(par_rd - SGR_BG_LO);
         else if (par_rd == SGR_FG_DF) fg_in = FG_WHITE;
         else if (par_rd == SGR_BG_DF) bg_in = BG_BLACK;
         sgr_in = sgr_ff + 1'b1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (cnt_ff == ADDR_LAST) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               if (req_data.func == FN_READ) state_in = ST_READ;
               else if (go_scroll) state_in = ST_SCROLL;
               else if (go_fill) state_in = ST_FILL;
               else if (go_sgr) state_in = ST_SGR;
               else state_in = ST_RESP;
            end
         end
         ST_READ:   state_in = ST_IDLE;
         ST_RESP:   state_in = ST_IDLE;
         ST_SGR:    if (sgr_ff == slot_ff) state_in = ST_RESP;
         ST_SCROLL: if (cnt_ff == SCR_LAST) state_in = ST_FILL;
         ST_FILL:   if (cnt_ff == ADDR_LAST) state_in = ST_RESP;
         default:   state_in = ST_IDLE;
      endcase
   end

   // memory port control and sweep counter
   always_comb begin
      cnt_in = cnt_ff;
      mem_we = 1'b0;
      mem_wa = ADDR_W'(32'(wr_row) * COLUMNS + 32'(wr_col));
      mem_wd = {bg_ff, fg_ff, wr_char};
      mem_ra = '0;
      unique case (state_ff)
         ST_CLEAR, ST_FILL: begin
            mem_we = 1'b1;
            mem_wa = cnt_ff;
            mem_wd = {bg_ff, fg_ff, CH_SPACE};
            cnt_in = cnt_ff + 1'b1;
         end
         ST_SCROLL: begin
            mem_we = (cnt_ff != '0);
            mem_wa = cnt_ff - 1'b1;
            mem_wd = mem_rd_ff;
            if (cnt_ff != SCR_LAST) mem_ra = ADDR_W'(32'(cnt_ff) + COLUMNS);
            cnt_in = (cnt_ff == SCR_LAST) ? SCR_LAST : cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            mem_we = idle_we;
            if (rd_in_range) begin
               mem_ra = ADDR_W'(32'(req_data.read_row) * COLUMNS + 32'(req_data.read_col));
            end
            cnt_in = go_fill ? '0 : '0;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) screen_mem[mem_wa] <= mem_wd;
      mem_rd_ff <= screen_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         mode_ff      <= MODE_NORMAL;
         crow_ff      <= '0;
         ccol_ff      <= '0;
         srow_ff      <= '0;
         scol_ff      <= '0;
         fg_ff        <= FG_WHITE;
         bg_ff        <= BG_BLACK;
         for (int i = 0; i < PARAM_SLOTS; i++) par_ff[i] <= 16'd0;
         slot_ff      <= '0;
         sgr_ff       <= '0;
         cnt_ff       <= '0;
         rd_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         crow_ff  <= crow_in;
         ccol_ff  <= ccol_in;
         srow_ff  <= srow_in;
         scol_ff  <= scol_in;
         fg_ff    <= fg_in;
         bg_ff    <= bg_in;
         par_ff   <= par_in;
         slot_ff  <= slot_in;
         sgr_ff   <= sgr_in;
         cnt_ff   <= cnt_in;
         rd_ok_ff <= rd_ok_in;
         if (state_ff == ST_READ || state_ff == ST_RESP) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ || state_ff == ST_RESP) begin
         if (state_ff == ST_READ && rd_ok_ff) begin
            rsp_ff.cell_char <= mem_rd_ff[7:0];
            rsp_ff.cell_fg   <= mem_rd_ff[11:8];
            rsp_ff.cell_bg   <= mem_rd_ff[15:12];
         end else begin
            rsp_ff.cell_char <= '0;
            rsp_ff.cell_fg   <= '0;
            rsp_ff.cell_bg   <= '0;
         end
         rsp_ff.cursor_row_out <= 5'(crow_ff);
         rsp_ff.cursor_col_out <= 7'(ccol_ff);
      end
   end

`ifndef SYNTHESIS
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      32'(crow_ff) < ROWS) else $error("cursor row out of range");
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      32'(ccol_ff) < COLUMNS) else $error("cursor column out of range");
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      32'(slot_ff) < PARAM_SLOTS) else $error("parameter slot out of range");
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      accept |=> !rsp_valid_ff) else $error("result register busy after accept");
   a_idle_write: assert property (@(posedge clock) disable iff (reset)
      (mem_we && state_ff == ST_IDLE) |-> accept) else $error("screen write without transaction");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_ansi_text_console_engine.sv -----
// tb_ansi_text_console_engine: self-checking bench for the ansi text console engine
// drives byte writes and cell reads, predicts every result with a behavioral screen model
// depends on ate_pkg and ansi_text_console_engine
`default_nettype none

module tb_ansi_text_console_engine;
   import ate_pkg::*;

   localparam int ROWS = ROWS_DEF;
   localparam int COLS = COLUMNS_DEF;
   localparam int SLOTS = PARAM_SLOTS_DEF;
   localparam int CYCLE_LIMIT = 20000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;

   ansi_text_console_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // screen model
   logic [15:0] scr [ROWS*COLS];
   int unsigned cur_r, cur_c, sav_r, sav_c, fg, bg, pslot;
   mode_type mode;
   int unsigned prm [SLOTS];

   rsp_type pending_cells [$];
   int errors = 0;
   int checked = 0;
   int writes_sent = 0;
   int reads_sent = 0;
   int cycles = 0;
   int tx_pct = 0;
   int rx_pct = 0;
   bit hold_rx = 1'b0;

   function automatic logic [15:0] paint(logic [7:0] ch);
      paint = {bg[3:0], fg[3:0], ch};
   endfunction

   function automatic void screen_reset();
      fg = FG_WHITE; bg = BG_BLACK;
      foreach (scr[i]) scr[i] = paint(CH_SPACE);
      cur_r = 0; cur_c = 0; sav_r = 0; sav_c = 0;
      mode = MODE_NORMAL; pslot = 0;
      foreach (prm[i]) prm[i] = 0;
   endfunction

   function automatic void advance_row();
      cur_r++;
      if (cur_r >= ROWS) begin
         for (int i = 0; i < (ROWS-1)*COLS; i++) scr[i] = scr[i+COLS];
         for (int i = (ROWS-1)*COLS; i < ROWS*COLS; i++) scr[i] = paint(CH_SPACE);
         cur_r = ROWS-1;
      end
   endfunction

   function automatic bit back_one();
      if (cur_c > 0) begin
         cur_c--; return 1;
      end
      if (cur_r > 0) begin
         cur_r--; cur_c = COLS-1; return 1;
      end
      return 0;
   endfunction

   function automatic rsp_type console_step(req_type rq);
      rsp_type rs;
      logic [7:0] b;
      int unsigned n, v, p;
      rs = '0;
      b = rq.char_byte;
      if (rq.func == FN_WRITE) begin
         if (mode == MODE_ESC) begin
            mode = MODE_NORMAL;
            if (b == CH_SAVE) begin
               sav_r = cur_r; sav_c = cur_c;
            end else if (b == CH_REST) begin
               cur_r = sav_r; cur_c = sav_c;
            end else if (b == CH_LBRK) begin
               foreach (prm[i]) prm[i] = 0;
               pslot = 0; mode = MODE_CSI;
            end
         end else if (mode == MODE_CSI) begin
            if (b >= CH_ZERO && b <= CH_NINE) begin
               v = prm[pslot] * 10 + (b - CH_ZERO);
               prm[pslot] = (v > PARAM_MAX) ? PARAM_MAX : v;
            end else if (b == CH_SEMI) begin
               if (pslot < SLOTS-1) pslot++;
            end else begin
               n = (prm[0] == 0) ? 1 : prm[0];
               if (b == CH_SGR) begin
                  for (int i = 0; i <= pslot; i++) begin
                     p = prm[i];
                     if (p >= SGR_FG_LO && p <= SGR_FG_HI) fg = p - SGR_FG_LO;
                     else if (p >= SGR_BG_LO && p <= SGR_BG_HI) bg = p - SGR_BG_LO;
                     else if (p == SGR_FG_DF) fg = FG_WHITE;
                     else if (p == SGR_BG_DF) bg = BG_BLACK;
                  end
               end else if (b == CH_LEFT) begin
                  cur_c = (n >= cur_c) ? 0 : cur_c - n;
               end else if (b == CH_RIGHT) begin
                  cur_c = (cur_c + n >= COLS) ? COLS-1 : cur_c + n;
               end else if (b == CH_POS_H || b == CH_POS_F) begin
                  cur_r = (prm[0] >= ROWS) ? ROWS-1 : prm[0];
                  cur_c = (prm[1] >= COLS) ? COLS-1 : prm[1];
               end else if (b == CH_ERASE) begin
                  if (prm[0] == ERASE_ALL) begin
                     foreach (scr[i]) scr[i] = paint(CH_SPACE);
                     cur_r = 0; cur_c = 0;
                  end
               end
               mode = MODE_NORMAL;
            end
         end else begin
            if (b == CH_ESC) mode = MODE_ESC;
            else if (b == CH_DEL) begin
               if (back_one()) scr[cur_r*COLS+cur_c] = paint(CH_SPACE);
            end else if (b == CH_BS) void'(back_one());
            else if (b == CH_CR) cur_c = 0;
            else if (b == CH_LF) advance_row();
            else if (b >= CH_SPACE && b <= CH_TILDE) begin
               scr[cur_r*COLS+cur_c] = paint(b);
               cur_c++;
               if (cur_c >= COLS) begin
                  cur_c = 0; advance_row();
               end
            end
         end
      end else if (rq.read_row < ROWS && rq.read_col < COLS) begin
         {rs.cell_bg, rs.cell_fg, rs.cell_char} = scr[rq.read_row*COLS+rq.read_col];
      end
      rs.cursor_row_out = cur_r[4:0];
      rs.cursor_col_out = cur_c[6:0];
      return rs;
   endfunction

   // drive one transaction, optionally checking the model's prediction against a given expected result
   task automatic send(req_type rq, bit fixed, rsp_type want);
      rsp_type got;
      if ($urandom_range(99) < tx_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < tx_pct) @(posedge clock);
      end
      got = console_step(rq);
      if (fixed && got !== want) begin
         errors++;
         if (errors <= 10)
            $display("directed row mismatch: model %h table %h", got, want);
      end
      pending_cells.push_back(got);
      if (rq.func == FN_WRITE) writes_sent++; else reads_sent++;
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic req_type wr(logic [7:0] b);
      wr = '0; wr.func = FN_WRITE; wr.char_byte = b;
      wr.read_row = 5'($urandom); wr.read_col = 7'($urandom);
   endfunction

   function automatic req_type rd(int r, int c);
      rd = '0; rd.func = FN_READ; rd.read_row = r[4:0]; rd.read_col = c[6:0];
      rd.char_byte = 8'($urandom);
   endfunction

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send(wr(s[i]), 0, '0);
   endtask

   task automatic send_random(int count);
      int k;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(99);
         if (k < 25) send(rd($urandom_range(ROWS), $urandom_range(COLS)), 0, '0);
         else if (k < 30) send(rd($urandom_range(31), $urandom_range(127)), 0, '0);
         else if (k < 55) send(wr(8'($urandom_range(CH_SPACE, CH_TILDE))), 0, '0);
         else if (k < 60) send(wr(8'($urandom)), 0, '0);
         else if (k < 70) begin
            case ($urandom_range(4))
               0: send(wr(CH_BS), 0, '0);
               1: send(wr(CH_DEL), 0, '0);
               2: send(wr(CH_CR), 0, '0);
               3: send(wr(CH_LF), 0, '0);
               default: begin
                  send(wr(CH_ESC), 0, '0);
                  send(wr($urandom_range(1) ? CH_SAVE : CH_REST), 0, '0);
               end
            endcase
         end else begin
            send(wr(CH_ESC), 0, '0);
            send(wr(CH_LBRK), 0, '0);
            case ($urandom_range(6))
               0: send_text($sformatf("%0d;%0dm", $urandom_range(29, 50),
                                      $urandom_range(29, 50)));
               1: send_text($sformatf("%0dD", $urandom_range(0, 90)));
               2: send_text($sformatf("%0dC", $urandom_range(0, 90)));
               3: send_text($sformatf("%0d;%0d%s", $urandom_range(0, 30),
                                      $urandom_range(0, 90),
                                      $urandom_range(1) ? "H" : "f"));
               4: send_text($urandom_range(7) == 0 ? "2J" : "1J");
               5: send_text($sformatf("%0d;%0d;%0dm", $urandom_range(30, 37),
                                      $urandom_range(40, 47), $urandom_range(0, 99)));
               default: send(wr(8'($urandom)), 0, '0);
            endcase
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (COLS*ROWS + 20) @(posedge clock);
   endtask

   // result checking
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_cells.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected transaction %h", rsp_data);
         end else begin
            if (rsp_data !== pending_cells[0]) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch: expected char %h fg %h bg %h row %0d col %0d,",
                            " got char %h fg %h bg %h row %0d col %0d"},
                     pending_cells[0].cell_char, pending_cells[0].cell_fg,
                     pending_cells[0].cell_bg, pending_cells[0].cursor_row_out,
                     pending_cells[0].cursor_col_out, rsp_data.cell_char,
                     rsp_data.cell_fg, rsp_data.cell_bg, rsp_data.cursor_row_out,
                     rsp_data.cursor_col_out);
            end
            void'(pending_cells.pop_front());
            checked++;
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= hold_rx ? 1'b1 : ($urandom_range(99) < rx_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   typedef struct {
      req_type rq;
      bit      fixed;
      rsp_type want;
   } step_row;

   step_row plan [$];

   function automatic rsp_type exp_cell(logic [7:0] ch, int f, int b, int r, int c);
      exp_cell.cell_char = ch; exp_cell.cell_fg = f[3:0]; exp_cell.cell_bg = b[3:0];
      exp_cell.cursor_row_out = r[4:0]; exp_cell.cursor_col_out = c[6:0];
   endfunction

   initial begin
      screen_reset();
      plan = '{
         '{rd(0, 0), 1, exp_cell(CH_SPACE, 7, 0, 0, 0)},
         '{rd(ROWS-1, COLS-1), 1, exp_cell(CH_SPACE, 7, 0, 0, 0)},
         '{rd(31, 127), 1, exp_cell(8'h00, 0, 0, 0, 0)},
         '{rd(ROWS, 0), 1, exp_cell(8'h00, 0, 0, 0, 0)},
         '{wr(CH_BS), 1, exp_cell(8'h00, 0, 0, 0, 0)},
         '{wr(CH_DEL), 1, exp_cell(8'h00, 0, 0, 0, 0)},
         '{wr(CH_TILDE), 1, exp_cell(8'h00, 0, 0, 0, 1)},
         '{wr(CH_SPACE), 1, exp_cell(8'h00, 0, 0, 0, 2)},
         '{wr(8'hFF), 1, exp_cell(8'h00, 0, 0, 0, 2)},
         '{wr(8'h00), 1, exp_cell(8'h00, 0, 0, 0, 2)},
         '{rd(0, 0), 1, exp_cell(CH_TILDE, 7, 0, 0, 2)},
         '{wr(CH_DEL), 0, '0},
         '{wr(CH_LF), 0, '0},
         '{wr(CH_CR), 0, '0},
         '{wr(CH_ESC), 0, '0},
         '{wr(8'h51), 0, '0},
         '{wr(CH_ESC), 0, '0},
         '{wr(CH_SAVE), 0, '0},
         '{wr(CH_BS), 0, '0},
         '{wr(CH_ESC), 0, '0},
         '{wr(CH_REST), 0, '0}
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (plan[i]) send(plan[i].rq, plan[i].fixed, plan[i].want);
      // sgr, moves, positioning clamps, overflow, erase, wrap and scroll
      send_text("\033[31;42mA\033[39;49;5mB\033[0D\033[99C\033[99;200H");
      send_text("\033[70000;1;2;3;4;5;6;7;8;9;10;11;12f\033[1;1X\033[2J");
      send_text("\033[24;79Hxy\n\033[1J");
      send(rd(ROWS-1, 0), 0, '0);
      send(rd(ROWS-2, COLS-1), 0, '0);
      tx_pct = 16; rx_pct = 87;
      send_random(90);
      tx_pct = 87; rx_pct = 16;
      send_random(60);
      tx_pct = 0; rx_pct = 0;
      drain();
      // long receiver hold-off while the sender keeps offering
      hold_rx = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_rx = 1'b0;
         end
         send_random(12);
      join
      send_random(100);
      drain();
      $display("covered %0d byte writes and %0d cell reads, %0d results checked",
               writes_sent, reads_sent, checked);
      $display("escape, csi, scroll, clear and out-of-screen reads under random back-pressure");
      if (errors == 0 && pending_cells.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
hw/rtl/ate_pkg.sv
hw/rtl/ansi_text_console_engine.sv
tb/sv/tb_ansi_text_console_engine.sv
